FILE: rtl/ray_kdop_slab_test_core_macros.svh
// Assertion macros used by the checker file of the slab test core.
`ifndef RAY_KDOP_SLAB_TEST_CORE_MACROS_SVH
`define RAY_KDOP_SLAB_TEST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RKST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RKST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rkst_pkg.sv
// Shared constants, axis table and state types of the slab test core.
package rkst_pkg;

	localparam int SLAB_IDX_W = 3;
	localparam int THR_W      = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd16;
	localparam int FRAC_BITS  = 16;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_comp_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_PREP,
		B_DOT,
		B_CHECK,
		B_DIV1,
		B_DIV2,
		B_NEXT,
		B_FINAL
	} back_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_PRE,
		DV_RUN,
		DV_DONE
	} div_state_t;

	// Coefficient of one component of one slab axis: x, y, z, then the diagonals.
	function automatic logic signed [1:0] axis_coef(
		input logic [SLAB_IDX_W-1:0] slab,
		input axis_comp_t            comp
	);
		logic signed [1:0] c;
		c = 2'sd0;
		unique case (slab)
			3'd0: c = (comp == AX_X) ? 2'sd1 : 2'sd0;
			3'd1: c = (comp == AX_Y) ? 2'sd1 : 2'sd0;
			3'd2: c = (comp == AX_Z) ? 2'sd1 : 2'sd0;
			3'd3: c = 2'sd1;
			3'd4: c = (comp == AX_X) ? -2'sd1 : 2'sd1;
			3'd5: c = (comp == AX_Z) ? 2'sd1 : -2'sd1;
			3'd6: c = (comp == AX_Y) ? -2'sd1 : 2'sd1;
			default: c = 2'sd0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/rkst_front.sv
// Front end: accepts items, drops out-of-range loads, queues commands.
module rkst_front #(
	parameter int SLAB_COUNT  = 7,
	parameter int COORD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_mode,
	input  logic [rkst_pkg::SLAB_IDX_W-1:0]   in_slab,
	input  logic signed [COORD_WIDTH-1:0]     in_a_x,
	input  logic signed [COORD_WIDTH-1:0]     in_a_y,
	input  logic signed [COORD_WIDTH-1:0]     in_a_z,
	input  logic signed [COORD_WIDTH-1:0]     in_b_x,
	input  logic signed [COORD_WIDTH-1:0]     in_b_y,
	input  logic signed [COORD_WIDTH-1:0]     in_b_z,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output logic                              cmd_query,
	output logic [rkst_pkg::SLAB_IDX_W-1:0]   cmd_slab,
	output logic signed [COORD_WIDTH-1:0]     cmd_a_x,
	output logic signed [COORD_WIDTH-1:0]     cmd_a_y,
	output logic signed [COORD_WIDTH-1:0]     cmd_a_z,
	output logic signed [COORD_WIDTH-1:0]     cmd_b_x,
	output logic signed [COORD_WIDTH-1:0]     cmd_b_y,
	output logic signed [COORD_WIDTH-1:0]     cmd_b_z
);
	import rkst_pkg::*;

	logic                           q_query_q [2];
	logic [SLAB_IDX_W-1:0]          q_slab_q  [2];
	logic signed [COORD_WIDTH-1:0]  q_ax_q    [2];
	logic signed [COORD_WIDTH-1:0]  q_ay_q    [2];
	logic signed [COORD_WIDTH-1:0]  q_az_q    [2];
	logic signed [COORD_WIDTH-1:0]  q_bx_q    [2];
	logic signed [COORD_WIDTH-1:0]  q_by_q    [2];
	logic signed [COORD_WIDTH-1:0]  q_bz_q    [2];
	logic                           wr_ptr_q;
	logic                           rd_ptr_q;
	logic [1:0]                     count_q;
	logic                           is_query;
	logic                           keep;
	logic                           push;
	logic                           pop;

	assign is_query  = (in_mode == MODE_QUERY);
	assign keep      = is_query || (in_slab < SLAB_IDX_W'(SLAB_COUNT));
	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;

	assign cmd_query = q_query_q[rd_ptr_q];
	assign cmd_slab  = q_slab_q[rd_ptr_q];
	assign cmd_a_x   = q_ax_q[rd_ptr_q];
	assign cmd_a_y   = q_ay_q[rd_ptr_q];
	assign cmd_a_z   = q_az_q[rd_ptr_q];
	assign cmd_b_x   = q_bx_q[rd_ptr_q];
	assign cmd_b_y   = q_by_q[rd_ptr_q];
	assign cmd_b_z   = q_bz_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_query_q[wr_ptr_q] <= is_query;
			q_slab_q[wr_ptr_q]  <= in_slab;
			q_ax_q[wr_ptr_q]    <= in_a_x;
			q_ay_q[wr_ptr_q]    <= in_a_y;
			q_az_q[wr_ptr_q]    <= in_a_z;
			q_bx_q[wr_ptr_q]    <= in_b_x;
			q_by_q[wr_ptr_q]    <= in_b_y;
			q_bz_q[wr_ptr_q]    <= in_b_z;
		end
	end

endmodule

FILE: rtl/rkst_div.sv
// Bit-serial saturating Q16.16 divider, one quotient bit per cycle.
module rkst_div #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [COORD_WIDTH+2:0]       num,
	input  logic signed [COORD_WIDTH+2:0]       den,
	output logic                                done,
	output logic signed [COORD_WIDTH-1:0]       quo
);
	import rkst_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int NW   = COORD_WIDTH + 3;
	localparam int CMPW = NW + W;
	localparam int CW   = $clog2(W);

	div_state_t        state_q, state_d;
	logic [NW-1:0]     nmag_q;
	logic [NW-1:0]     dmag_q;
	logic              neg_q;
	logic              sat_q;
	logic [NW:0]       rem_q;
	logic [W-2:0]      low_q;
	logic [CW-1:0]     cnt_q;
	logic [NW+15:0]    nfull;
	logic [NW+15:0]    nshift;
	logic              sat_now;
	logic [NW:0]       trial;
	logic              fits;
	logic [W-1:0]      raw;
	logic              take;

	assign take    = start && (state_q == DV_IDLE || state_q == DV_DONE);
	assign nfull   = {nmag_q, {FRAC_BITS{1'b0}}};
	assign nshift  = nfull >> (W - 1);
	assign sat_now = CMPW'(nfull) >= (CMPW'(dmag_q) << (W - 1));
	assign trial   = {rem_q[NW-1:0], low_q[W-2]};
	assign fits    = trial >= {1'b0, dmag_q};
	assign raw     = {1'b0, low_q};
	assign done    = (state_q == DV_DONE);

	always_comb begin
		if (sat_q)
			quo = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			quo = neg_q ? -$signed(raw) : $signed(raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= DV_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (take) state_d = DV_PRE;
			DV_PRE: state_d = sat_now ? DV_DONE : DV_RUN;
			DV_RUN: if (cnt_q == CW'(0)) state_d = DV_DONE;
			DV_DONE: state_d = take ? DV_PRE : DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			nmag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			dmag_q <= den[NW-1] ? NW'(-den) : NW'(den);
			neg_q  <= num[NW-1] != den[NW-1];
		end
		if (state_q == DV_PRE) begin
			sat_q <= sat_now;
			rem_q <= {1'b0, nshift[NW-1:0]};
			low_q <= nfull[W-2:0];
			cnt_q <= CW'(W - 2);
		end
		if (state_q == DV_RUN) begin
			rem_q <= fits ? (trial - {1'b0, dmag_q}) : trial;
			low_q <= {low_q[W-3:0], fits};
			cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

FILE: rtl/rkst_back.sv
// Back end: slab corner store, per-slab projection and interval sequencer.
module rkst_back #(
	parameter int SLAB_COUNT  = 7,
	parameter int COORD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [rkst_pkg::THR_W-1:0]        threshold,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic                              cmd_query,
	input  logic [rkst_pkg::SLAB_IDX_W-1:0]   cmd_slab,
	input  logic signed [COORD_WIDTH-1:0]     cmd_a_x,
	input  logic signed [COORD_WIDTH-1:0]     cmd_a_y,
	input  logic signed [COORD_WIDTH-1:0]     cmd_a_z,
	input  logic signed [COORD_WIDTH-1:0]     cmd_b_x,
	input  logic signed [COORD_WIDTH-1:0]     cmd_b_y,
	input  logic signed [COORD_WIDTH-1:0]     cmd_b_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_hit
);
	import rkst_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int NW = COORD_WIDTH + 3;
	localparam int LW = COORD_WIDTH + 2;
	localparam int SW = $clog2(SLAB_COUNT);

	logic signed [W-1:0]   min_x_q [SLAB_COUNT];
	logic signed [W-1:0]   min_y_q [SLAB_COUNT];
	logic signed [W-1:0]   min_z_q [SLAB_COUNT];
	logic signed [W-1:0]   max_x_q [SLAB_COUNT];
	logic signed [W-1:0]   max_y_q [SLAB_COUNT];
	logic signed [W-1:0]   max_z_q [SLAB_COUNT];

	back_state_t           state_q, state_d;
	logic signed [W-1:0]   ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic [SW-1:0]         slab_q;
	logic                  hit_q;
	logic signed [LW-1:0]  lo_q, hi_q;
	logic signed [W:0]     dminx_s1, dminy_s1, dminz_s1;
	logic signed [W:0]     dmaxx_s1, dmaxy_s1, dmaxz_s1;
	logic signed [NW-1:0]  den_s1;
	logic signed [NW-1:0]  n1_s2, n2_s2;
	logic signed [W-1:0]   t1_q;
	logic                  out_valid_q, out_hit_q;

	logic [SLAB_IDX_W-1:0] slab_ext;
	logic signed [1:0]     cx, cy, cz;
	logic signed [NW-1:0]  den_c, n1_c, n2_c;
	logic [NW-1:0]         den_mag;
	logic                  parallel;
	logic                  same_side;
	logic                  div_start, div_done;
	logic signed [NW-1:0]  div_num;
	logic signed [W-1:0]   div_quo;
	logic signed [W-1:0]   tn, tx;
	logic signed [LW-1:0]  tn_ext, tx_ext;
	logic                  last_slab;

	function automatic logic signed [NW-1:0] scale(
		input logic signed [1:0]   c,
		input logic signed [NW-1:0] v
	);
		logic signed [NW-1:0] r;
		r = '0;
		if (c == 2'sd1)
			r = v;
		else if (c == -2'sd1)
			r = -v;
		return r;
	endfunction

	assign slab_ext = SLAB_IDX_W'(slab_q);
	assign cx = axis_coef(slab_ext, AX_X);
	assign cy = axis_coef(slab_ext, AX_Y);
	assign cz = axis_coef(slab_ext, AX_Z);

	assign den_c = scale(cx, NW'(bx_q)) + scale(cy, NW'(by_q)) + scale(cz, NW'(bz_q));
	assign n1_c  = scale(cx, NW'(dminx_s1)) + scale(cy, NW'(dminy_s1))
		+ scale(cz, NW'(dminz_s1));
	assign n2_c  = scale(cx, NW'(dmaxx_s1)) + scale(cy, NW'(dmaxy_s1))
		+ scale(cz, NW'(dmaxz_s1));

	assign den_mag   = den_s1[NW-1] ? NW'(-den_s1) : NW'(den_s1);
	assign parallel  = (den_s1 == '0) || (den_mag < NW'(threshold));
	assign same_side = ((n1_s2 == '0) && (n2_s2 == '0))
		|| ((n1_s2 > 0) && (n2_s2 > 0))
		|| ((n1_s2 < 0) && (n2_s2 < 0));

	assign tn     = (t1_q < div_quo) ? t1_q : div_quo;
	assign tx     = (t1_q < div_quo) ? div_quo : t1_q;
	assign tn_ext = LW'(tn);
	assign tx_ext = LW'(tx);
	assign last_slab = (slab_q == SW'(SLAB_COUNT - 1));

	assign cmd_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;

	rkst_div #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_s1),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = n1_s2;
		unique case (state_q)
			B_IDLE: if (cmd_valid && cmd_query) state_d = B_PREP;
			B_PREP: state_d = B_DOT;
			B_DOT: state_d = B_CHECK;
			B_CHECK: begin
				if (parallel)
					state_d = same_side ? B_FINAL : B_NEXT;
				else begin
					div_start = 1'b1;
					state_d   = B_DIV1;
				end
			end
			B_DIV1: begin
				div_num = n2_s2;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = B_DIV2;
				end
			end
			B_DIV2: if (div_done) state_d = (tx < 0) ? B_FINAL : B_NEXT;
			B_NEXT: state_d = last_slab ? B_FINAL : B_PREP;
			B_FINAL: if (!out_valid_q) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == B_FINAL && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && cmd_valid) begin
			if (cmd_query) begin
				ax_q   <= cmd_a_x;
				ay_q   <= cmd_a_y;
				az_q   <= cmd_a_z;
				bx_q   <= cmd_b_x;
				by_q   <= cmd_b_y;
				bz_q   <= cmd_b_z;
				slab_q <= '0;
				hit_q  <= 1'b1;
				lo_q   <= -(LW'(1) <<< W);
				hi_q   <= LW'(1) <<< W;
			end else begin
				min_x_q[cmd_slab[SW-1:0]] <= cmd_a_x;
				min_y_q[cmd_slab[SW-1:0]] <= cmd_a_y;
				min_z_q[cmd_slab[SW-1:0]] <= cmd_a_z;
				max_x_q[cmd_slab[SW-1:0]] <= cmd_b_x;
				max_y_q[cmd_slab[SW-1:0]] <= cmd_b_y;
				max_z_q[cmd_slab[SW-1:0]] <= cmd_b_z;
			end
		end
		if (state_q == B_PREP) begin
			dminx_s1 <= (W+1)'(min_x_q[slab_q]) - (W+1)'(ax_q);
			dminy_s1 <= (W+1)'(min_y_q[slab_q]) - (W+1)'(ay_q);
			dminz_s1 <= (W+1)'(min_z_q[slab_q]) - (W+1)'(az_q);
			dmaxx_s1 <= (W+1)'(max_x_q[slab_q]) - (W+1)'(ax_q);
			dmaxy_s1 <= (W+1)'(max_y_q[slab_q]) - (W+1)'(ay_q);
			dmaxz_s1 <= (W+1)'(max_z_q[slab_q]) - (W+1)'(az_q);
			den_s1   <= den_c;
		end
		if (state_q == B_DOT) begin
			n1_s2 <= n1_c;
			n2_s2 <= n2_c;
		end
		if (state_q == B_CHECK && parallel && same_side)
			hit_q <= 1'b0;
		if (state_q == B_DIV1 && div_done)
			t1_q <= div_quo;
		if (state_q == B_DIV2 && div_done) begin
			if (tx < 0)
				hit_q <= 1'b0;
			else begin
				if (tn_ext > lo_q)
					lo_q <= tn_ext;
				if (tx_ext < hi_q)
					hi_q <= tx_ext;
			end
		end
		if (state_q == B_NEXT && !last_slab)
			slab_q <= slab_q + SW'(1);
		if (state_q == B_FINAL && !out_valid_q)
			out_hit_q <= hit_q && !(hi_q < lo_q);
	end

endmodule

FILE: rtl/ray_kdop_slab_test_core.sv
// Top level of the ray against seven-axis discrete oriented box test.
// Input channel s_axis: tuser is the mode (0 loads one slab's min and max
// corners, 1 runs a ray query); tdata carries slab_index and the a and b
// vectors. A load writes the corner store and gives no result; a query
// gives one result item on m_axis, tdata bit 0 = hit.
// cfg_we/cfg_wdata write the parallel threshold (Q16.16 raw magnitude).
// A load is written to the corner store while the back end is idle. A
// query walks the slabs one at a time through the prep, dot and check
// states; a slab that is not parallel also passes DIV1 and DIV2, where the
// single bit-serial divider forms both slab t values in turn.
// A query stops early once a slab rules out a hit.
// A two-entry queue between the front end and the back end keeps s_axis
// ready while the back end is busy, until the queue fills.
// If m_axis stalls, the result waits in the output register and the back
// end goes on; a further query's result waits until the register is free.
// Reset clears the queue, the sequencer and the output valid and sets the
// threshold to 16; the corner store must be loaded before it is queried.
module ray_kdop_slab_test_core #(
	parameter int SLAB_COUNT  = 7,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// slab_index, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, zero pad
	input  logic [((3 + 6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// mode
	input  logic                                          s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// hit, zero pad
	output logic [7:0]                                    m_axis_tdata,
	input  logic                                          cfg_we,
	input  logic [rkst_pkg::THR_W-1:0]                    cfg_wdata
);
	import rkst_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int B0 = SLAB_IDX_W;

	logic [THR_W-1:0]      threshold_q;
	logic                  cmd_valid, cmd_ready, cmd_query;
	logic [SLAB_IDX_W-1:0] cmd_slab;
	logic signed [W-1:0]   cmd_a_x, cmd_a_y, cmd_a_z, cmd_b_x, cmd_b_y, cmd_b_z;
	logic                  out_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THR_RESET;
		else if (cfg_we)
			threshold_q <= cfg_wdata;
	end

	rkst_front #(
		.SLAB_COUNT  (SLAB_COUNT),
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_slab   (s_axis_tdata[SLAB_IDX_W-1:0]),
		.in_a_x    (s_axis_tdata[B0 + 0 * W +: W]),
		.in_a_y    (s_axis_tdata[B0 + 1 * W +: W]),
		.in_a_z    (s_axis_tdata[B0 + 2 * W +: W]),
		.in_b_x    (s_axis_tdata[B0 + 3 * W +: W]),
		.in_b_y    (s_axis_tdata[B0 + 4 * W +: W]),
		.in_b_z    (s_axis_tdata[B0 + 5 * W +: W]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_query (cmd_query),
		.cmd_slab  (cmd_slab),
		.cmd_a_x   (cmd_a_x),
		.cmd_a_y   (cmd_a_y),
		.cmd_a_z   (cmd_a_z),
		.cmd_b_x   (cmd_b_x),
		.cmd_b_y   (cmd_b_y),
		.cmd_b_z   (cmd_b_z)
	);

	rkst_back #(
		.SLAB_COUNT  (SLAB_COUNT),
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_query (cmd_query),
		.cmd_slab  (cmd_slab),
		.cmd_a_x   (cmd_a_x),
		.cmd_a_y   (cmd_a_y),
		.cmd_a_z   (cmd_a_z),
		.cmd_b_x   (cmd_b_x),
		.cmd_b_y   (cmd_b_y),
		.cmd_b_z   (cmd_b_z),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_hit   (out_hit)
	);

	assign m_axis_tdata = {7'd0, out_hit};

endmodule

FILE: rtl/rkst_checker.sv
// Port-level checker for the slab test core and its bind.
`include "ray_kdop_slab_test_core_macros.svh"

module rkst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	`RKST_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item dropped or changed while stalled")
	`RKST_ASSERT_IMP(a_out_pad, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0, "result padding bits not zero")
	`RKST_ASSERT_NXT(a_out_gap, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "result items back to back")

endmodule

bind ray_kdop_slab_test_core rkst_checker u_rkst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/ray_kdop_slab_test_core_test.sv
// Testbench for the ray against seven-axis discrete oriented box test core.
module ray_kdop_slab_test_core_test;
	import rkst_pkg::*;

	localparam int CW = 32;
	localparam int DRAIN_CYCLES = 700;

	class slab_scoreboard;
		longint min_corner[21];
		longint max_corner[21];
		longint threshold;
		bit hit_queue[$];
		int errors;
		int loads;
		int queries;
		int hits;

		function new();
			threshold = THR_RESET;
			errors = 0;
			loads = 0;
			queries = 0;
			hits = 0;
		endfunction

		function int coef(int s, int c);
			case (s)
				0: return (c == 0) ? 1 : 0;
				1: return (c == 1) ? 1 : 0;
				2: return (c == 2) ? 1 : 0;
				3: return 1;
				4: return (c == 0) ? -1 : 1;
				5: return (c == 2) ? 1 : -1;
				default: return (c == 1) ? -1 : 1;
			endcase
		endfunction

		function int sign_of(longint v);
			return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
		endfunction

		function longint fixed_div(longint num, longint den);
			bit neg;
			longint unsigned n, d, q, r, frac, raw, maxraw;
			longint most_neg;
			neg = (num < 0) != (den < 0);
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			maxraw = (64'd1 << (CW - 1)) - 1;
			most_neg = -(64'sd1 <<< (CW - 1));
			q = n / d;
			r = n % d;
			frac = 0;
			if (q > (maxraw >> 16))
				return neg ? most_neg : longint'(maxraw);
			for (int i = 0; i < 16; i++) begin
				r = r << 1;
				frac = frac << 1;
				if (r >= d) begin
					r = r - d;
					frac = frac | 1;
				end
			end
			raw = q * 65536 + frac;
			if (raw > maxraw)
				return neg ? most_neg : longint'(maxraw);
			return neg ? -longint'(raw) : longint'(raw);
		endfunction

		function void note_item(logic mode, logic [2:0] idx, logic [2:0][31:0] va,
				logic [2:0][31:0] vb);
			longint a[3], b[3];
			longint lo, hi, den, n1, n2, t1, t2, tn, tx, mag;
			bit h;
			for (int c = 0; c < 3; c++) begin
				a[c] = longint'($signed(va[c]));
				b[c] = longint'($signed(vb[c]));
			end
			if (mode == MODE_LOAD) begin
				loads++;
				if (idx < 7)
					for (int c = 0; c < 3; c++) begin
						min_corner[idx * 3 + c] = a[c];
						max_corner[idx * 3 + c] = b[c];
					end
				return;
			end
			queries++;
			lo = -(64'sd1 <<< CW);
			hi = 64'sd1 <<< CW;
			h = 1;
			for (int s = 0; s < 7 && h; s++) begin
				den = 0;
				n1 = 0;
				n2 = 0;
				for (int c = 0; c < 3; c++) begin
					den += coef(s, c) * b[c];
					n1 += coef(s, c) * (min_corner[s * 3 + c] - a[c]);
					n2 += coef(s, c) * (max_corner[s * 3 + c] - a[c]);
				end
				mag = (den < 0) ? -den : den;
				if (den == 0 || mag < threshold) begin
					if (sign_of(n1) == sign_of(n2))
						h = 0;
					continue;
				end
				t1 = fixed_div(n1, den);
				t2 = fixed_div(n2, den);
				tn = (t1 < t2) ? t1 : t2;
				tx = (t1 < t2) ? t2 : t1;
				if (tx < 0) begin
					h = 0;
					continue;
				end
				if (tn > lo)
					lo = tn;
				if (tx < hi)
					hi = tx;
			end
			if (h && hi < lo)
				h = 0;
			hits += h;
			hit_queue.push_back(h);
		endfunction

		function void check_result(logic got);
			bit want;
			if (hit_queue.size() == 0) begin
				$error("hit: unexpected result item, actual %0d", got);
				errors++;
				return;
			end
			want = hit_queue.pop_front();
			if (want !== got) begin
				$error("hit mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return hit_queue.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [199:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	slab_scoreboard sb;
	int send_idle;
	int recv_idle;

	ray_kdop_slab_test_core #(.SLAB_COUNT(7), .COORD_WIDTH(CW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 0;
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[0]);
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(logic mode, logic [2:0] idx, logic [2:0][31:0] va,
			logic [2:0][31:0] vb);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {5'd0, vb[2], vb[1], vb[0], va[2], va[1], va[0], idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(mode, idx, va, vb);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(logic [THR_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = v;
	endtask

	function automatic logic [2:0][31:0] vec3(int x, int y, int z);
		return {32'(z), 32'(y), 32'(x)};
	endfunction

	function automatic logic [2:0][31:0] any_vec();
		return {$urandom(), $urandom(), $urandom()};
	endfunction

	function automatic int spread(int r);
		return int'($urandom_range(2 * r)) - r;
	endfunction

	task automatic load_box(int r);
		for (int s = 0; s < 7; s++)
			send_item(MODE_LOAD, 3'(s), vec3(-r, -r, -r), vec3(r, r, r));
	endtask

	task automatic random_item();
		int r, k;
		logic [2:0][31:0] va, vb;
		k = $urandom_range(99);
		if (k < 20) begin
			r = $urandom_range(1 << 14, 1 << 22);
			va = vec3(-r + spread(r / 4), -r + spread(r / 4), -r + spread(r / 4));
			vb = vec3(r + spread(r / 4), r + spread(r / 4), r + spread(r / 4));
			if ($urandom_range(9) == 0) begin
				va = any_vec();
				vb = any_vec();
			end
			send_item(MODE_LOAD, 3'($urandom_range(7)), va, vb);
		end else begin
			r = 1 << $urandom_range(12, 23);
			va = vec3(spread(r), spread(r), spread(r));
			vb = vec3(-$signed(va[0]) + spread(r / 2), -$signed(va[1]) + spread(r / 2),
				-$signed(va[2]) + spread(r / 2));
			if (k < 30)
				vb[$urandom_range(2)] = 32'd0;
			else if (k < 35)
				vb = vec3(spread(20), spread(20), spread(20));
			else if (k < 45) begin
				va = any_vec();
				vb = any_vec();
			end
			send_item(MODE_QUERY, 3'($urandom_range(7)), va, vb);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_LOAD;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_idle = 0;
		recv_idle = 0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unit-ish box, threshold at reset value
		load_box(32'h0001_0000);
		send_item(MODE_QUERY, 3'd0, vec3(-3 << 16, 0, 0), vec3(1 << 16, 0, 0));
		send_item(MODE_QUERY, 3'd0, vec3(-3 << 16, 5 << 16, 0), vec3(1 << 16, 0, 0));
		send_item(MODE_QUERY, 3'd0, vec3(0, 0, 0), vec3(0, 0, 0));
		send_item(MODE_QUERY, 3'd0, vec3(0, 0, 0), vec3(0, 0, 1));
		send_item(MODE_QUERY, 3'd0, vec3(3 << 16, 0, 0), vec3(1 << 16, 0, 0));
		send_item(MODE_QUERY, 3'd0, vec3(1 << 16, 1 << 16, 1 << 16), vec3(1, 1, 1));
		send_item(MODE_QUERY, 3'd7, vec3(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
			vec3(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send_item(MODE_QUERY, 3'd0, vec3(32'h7fff_ffff, 0, 0), vec3(-1, 0, 0));
		send_item(MODE_QUERY, 3'd0, vec3(-2 << 16, 0, 0), vec3(1, 0, 0));
		send_item(MODE_QUERY, 3'd0, vec3(-2 << 16, -2 << 16, 0), vec3(32'h8000_0000, 1, 0));
		send_item(MODE_LOAD, 3'd7, vec3(5, 5, 5), vec3(-5, -5, -5));
		send_item(MODE_LOAD, 3'd3, vec3(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
			vec3(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send_item(MODE_QUERY, 3'd0, vec3(-1 << 16, -1 << 16, -1 << 16),
			vec3(1 << 16, 1 << 16, 1 << 16));
		send_item(MODE_QUERY, 3'd0, vec3(1 << 16, 1 << 16, 1 << 16), vec3(1, 2, 3));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin set_threshold(16'd0); send_idle = 31; recv_idle = 59; end
				1: begin set_threshold(16'hffff); send_idle = 59; recv_idle = 31; end
				2: begin set_threshold(16'($urandom())); send_idle = 0; recv_idle = 0; end
				default: begin set_threshold(THR_RESET); send_idle = 0; recv_idle = 0; end
			endcase
			load_box($urandom_range(1 << 16, 1 << 22));
			repeat (200) random_item();
			drain();
		end

		$display("covered %0d loads and %0d queries (%0d hits) over five threshold settings",
			sb.loads, sb.queries, sb.hits);
		$display("idle patterns: sender-heavy, receiver-heavy and none");
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#60000000;
		$display("tb: failure");
		$finish;
	end
endmodule

FILE: ray_kdop_slab_test_core.f
+incdir+rtl
rtl/rkst_pkg.sv
rtl/rkst_front.sv
rtl/rkst_div.sv
rtl/rkst_back.sv
rtl/ray_kdop_slab_test_core.sv
rtl/rkst_checker.sv
tb/sv/ray_kdop_slab_test_core_test.sv
